>>> design/spl_pkg.sv
`timescale 1ns / 1ps

package spl_pkg;

	localparam int ECHO_BITS_DEF   = 24;
	localparam int HOLD_BITS       = 26;
	localparam int THR_BITS        = 16;
	localparam int PAUSE_BITS      = 20;
	localparam int RANGE_BITS      = 19;
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 26;
	localparam int REM_BITS        = 7;

	localparam int RADIX           = 100;
	// 172 = 1 * 100 + 72
	localparam int STEP_REM        = 72;

	localparam logic [HOLD_BITS-1:0]  HOLD_RESET  = HOLD_BITS'(10000000);
	localparam logic [THR_BITS-1:0]   THR_RESET   = THR_BITS'(50);
	localparam logic [PAUSE_BITS-1:0] PAUSE_RESET = PAUSE_BITS'(50000);

	typedef enum logic [1:0] {
		PH_PAUSE   = 2'd0,
		PH_TRIGGER = 2'd1,
		PH_COUNT   = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_HOLD  = 2'd0,
		CFG_THR   = 2'd1,
		CFG_PAUSE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [HOLD_BITS-1:0]  hold_ticks;
		logic [THR_BITS-1:0]   near_thr;
		logic [PAUSE_BITS-1:0] pause_ticks;
	} cfg_t;

	typedef struct packed {
		logic                  trigger;
		logic                  valid;
		logic                  near;
		logic [RANGE_BITS-1:0] range;
	} step_res_t;

endpackage

>>> design/spl_in_if.sv
`timescale 1ns / 1ps

interface spl_in_if;
	logic valid;
	logic ready;
	logic echo_level;

	modport source (output valid, output echo_level, input ready);
	modport sink (input valid, input echo_level, output ready);
endinterface

>>> design/spl_out_if.sv
`timescale 1ns / 1ps

interface spl_out_if;
	logic                           valid;
	logic                           ready;
	logic                           trigger_active;
	logic                           light_on;
	logic                           range_valid;
	logic [spl_pkg::RANGE_BITS-1:0] range_cm;

	modport source (output valid, output trigger_active, output light_on,
		output range_valid, output range_cm, input ready);
	modport sink (input valid, input trigger_active, input light_on,
		input range_valid, input range_cm, output ready);
endinterface

>>> design/spl_cfg_if.sv
`timescale 1ns / 1ps

interface spl_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [spl_pkg::CFG_IDX_BITS-1:0]  index;
	logic [spl_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/spl_cfg_regs.sv
`timescale 1ns / 1ps

module spl_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	spl_cfg_if.sink       cfg,
	output spl_pkg::cfg_t regs
);

	spl_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hold_ticks  <= spl_pkg::HOLD_RESET;
			regs_q.near_thr    <= spl_pkg::THR_RESET;
			regs_q.pause_ticks <= spl_pkg::PAUSE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spl_pkg::CFG_HOLD: begin
					regs_q.hold_ticks <= cfg.data[spl_pkg::HOLD_BITS-1:0];
				end
				spl_pkg::CFG_THR: begin
					regs_q.near_thr <= cfg.data[spl_pkg::THR_BITS-1:0];
				end
				spl_pkg::CFG_PAUSE: begin
					regs_q.pause_ticks <= cfg.data[spl_pkg::PAUSE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> design/spl_ranger.sv
`timescale 1ns / 1ps

module spl_ranger #(
	parameter int ECHO_COUNT_BITS = spl_pkg::ECHO_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               echo,
	input  spl_pkg::cfg_t      cfg,
	output spl_pkg::step_res_t res
);

	localparam int Q2W = ECHO_COUNT_BITS + 1;
	localparam int EXW = Q2W + spl_pkg::RANGE_BITS;
	localparam int RW  = spl_pkg::REM_BITS;

	spl_pkg::phase_t                phase_q, phase_d;
	logic [ECHO_COUNT_BITS-1:0]     echo_q, echo_d;
	// echo ticks mod 100, and range kept as quotient/remainder of (ticks/100)*172 by 100
	logic [RW-1:0]                  r1_q, r1_d;
	logic [RW-1:0]                  r2_q, r2_d;
	logic [Q2W-1:0]                 q2_q, q2_d;
	logic [spl_pkg::PAUSE_BITS-1:0] pause_q, pause_d, pause_inc;
	logic [RW:0]                    r2_sum;
	logic [EXW-1:0]                 q2_ext;
	logic [spl_pkg::RANGE_BITS-1:0] range_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= spl_pkg::PH_PAUSE;
			echo_q  <= '0;
			r1_q    <= '0;
			r2_q    <= '0;
			q2_q    <= '0;
			pause_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			echo_q  <= echo_d;
			r1_q    <= r1_d;
			r2_q    <= r2_d;
			q2_q    <= q2_d;
			pause_q <= pause_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		echo_d    = echo_q;
		r1_d      = r1_q;
		r2_d      = r2_q;
		q2_d      = q2_q;
		pause_d   = pause_q;
		r2_sum    = (RW + 1)'(r2_q) + (RW + 1)'(spl_pkg::STEP_REM);
		pause_inc = (&pause_q) ? pause_q : pause_q + 1'b1;
		q2_ext    = EXW'(q2_q);
		range_sat = (|q2_ext[EXW-1:spl_pkg::RANGE_BITS]) ? '1 :
			q2_ext[spl_pkg::RANGE_BITS-1:0];
		res       = '0;

		unique case (phase_q)
			spl_pkg::PH_TRIGGER: begin
				if (echo) begin
					echo_d  = '0;
					r1_d    = '0;
					r2_d    = '0;
					q2_d    = '0;
					phase_d = spl_pkg::PH_COUNT;
				end
			end
			spl_pkg::PH_COUNT: begin
				if (echo) begin
					if (echo_q != '1) begin
						echo_d = echo_q + 1'b1;
						if (r1_q == RW'(spl_pkg::RADIX - 1)) begin
							r1_d = '0;
							if (r2_sum >= (RW + 1)'(spl_pkg::RADIX)) begin
								r2_d = RW'(r2_sum - (RW + 1)'(spl_pkg::RADIX));
								q2_d = q2_q + Q2W'(2);
							end else begin
								r2_d = r2_sum[RW-1:0];
								q2_d = q2_q + Q2W'(1);
							end
						end else begin
							r1_d = r1_q + 1'b1;
						end
					end
				end else begin
					res.valid = 1'b1;
					res.range = range_sat;
					res.near  = range_sat < spl_pkg::RANGE_BITS'(cfg.near_thr);
					pause_d   = '0;
					phase_d   = spl_pkg::PH_PAUSE;
				end
			end
			default: begin
				pause_d = pause_inc;
				phase_d = (pause_inc >= cfg.pause_ticks) ? spl_pkg::PH_TRIGGER :
					spl_pkg::PH_PAUSE;
			end
		endcase

		res.trigger = (phase_d == spl_pkg::PH_TRIGGER);
	end

endmodule

>>> design/spl_hold.sv
`timescale 1ns / 1ps

module spl_hold (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          clear,
	input  logic [spl_pkg::HOLD_BITS-1:0] hold_ticks,
	output logic                          light
);

	logic [spl_pkg::HOLD_BITS-1:0] hold_q, hold_d;

	always_comb begin
		hold_d = (hold_q < hold_ticks) ? hold_q + 1'b1 : hold_ticks;
		if (clear) begin
			hold_d = '0;
		end
		light = hold_d < hold_ticks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= spl_pkg::HOLD_RESET;
		end else if (step) begin
			hold_q <= hold_d;
		end
	end

endmodule

>>> design/sonar_proximity_light_timer.sv
`timescale 1ns / 1ps
// An item is taken into the input register, then its result into the output register.
// One item per cycle unless results stall; incremental counters keep the range, so no divider.
// Stalls on the result side back up through the input register only.
// Reset (arst_n low, asynchronous): pause phase, echo and pause counters zero,
// hold counter at the hold time (light off), registers at hold 10000000,
// threshold 50, pause 50000.

module sonar_proximity_light_timer #(
	parameter int ECHO_COUNT_BITS = spl_pkg::ECHO_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	spl_in_if.sink     echo,
	spl_out_if.source  result,
	spl_cfg_if.sink    cfg
);

	spl_pkg::cfg_t      regs;
	spl_pkg::step_res_t res;
	logic               light;
	logic               adv;
	logic               vld_s1;
	logic               echo_s1;
	logic               out_vld_q;
	logic               trig_q;
	logic               light_q;
	logic               rvalid_q;
	logic [spl_pkg::RANGE_BITS-1:0] range_q;

	assign adv        = vld_s1 && (!out_vld_q || result.ready);
	assign echo.ready = !vld_s1 || adv;

	spl_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	spl_ranger #(
		.ECHO_COUNT_BITS (ECHO_COUNT_BITS)
	) u_ranger (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.echo   (echo_s1),
		.cfg    (regs),
		.res    (res)
	);

	spl_hold u_hold (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.clear      (res.valid && res.near),
		.hold_ticks (regs.hold_ticks),
		.light      (light)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (echo.ready) begin
			vld_s1 <= echo.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (echo.valid && echo.ready) begin
			echo_s1 <= echo.echo_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trig_q   <= res.trigger;
			light_q  <= light;
			rvalid_q <= res.valid;
			range_q  <= res.range;
		end
	end

	assign result.valid          = out_vld_q;
	assign result.trigger_active = trig_q;
	assign result.light_on       = light_q;
	assign result.range_valid    = rvalid_q;
	assign result.range_cm       = range_q;

`ifndef NO_ASSERTIONS
	a_done_not_trig: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.range_valid |-> !result.trigger_active)
		else $error("trigger shown on a completed measurement");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.range_valid |-> result.range_cm == '0)
		else $error("range nonzero without completed measurement");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!echo.ready |-> vld_s1 && out_vld_q && !result.ready)
		else $error("input stalled while pipeline can move");

	a_adv_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_vld_q)
		else $error("result register not loaded after advance");
`endif

endmodule
